### rtl/nmea_coordinate_to_degrees_e7_macros.svh
// ----------------------------------------------------------------------------
// NMEA coordinate converter assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_COORDINATE_TO_DEGREES_E7_MACROS_SVH
`define NMEA_COORDINATE_TO_DEGREES_E7_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMEACD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMEACD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nmeacd_pkg.sv
// ----------------------------------------------------------------------------
// NMEA coordinate converter package
// Types, character codes and width helpers shared by the controller and the
// datapath of the ddmm.mmmm to degrees-times-1e7 converter.
// ----------------------------------------------------------------------------
package nmeacd_pkg;

  // Default digit limits.
  localparam int unsigned MAX_FRAC_DIGITS_DEF = 7;
  localparam int unsigned MAX_INT_DIGITS_DEF  = 5;

  // Output scale and the widths tied to it.
  localparam longint unsigned E7     = 64'd10000000;
  localparam int unsigned     E7_W   = 24;
  localparam int unsigned     FQ_W   = 25;  // bits of the rounded minutes quotient
  localparam int unsigned     MULC_W = 25;  // bits of the constant 2 * 1e7
  localparam logic [MULC_W-1:0] TWO_E7 = MULC_W'(2 * E7);

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_SUM
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_char;
    logic end_field;
    logic div_step;
    logic start_mul;
    logic mul_step;
    logic start_div2;
    logic write_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic field_ok;
    logic out_free;
  } sts_t;

  // Power of ten for elaboration-time width math.
  function automatic longint unsigned pow10_c(input int unsigned k);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < k; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic int unsigned max3(input int unsigned a, input int unsigned b,
                                       input int unsigned c);
    int unsigned m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Mantissa holds up to int + frac decimal digits.
  function automatic int unsigned mant_w(input int unsigned i, input int unsigned f);
    return $clog2(pow10_c(i + f));
  endfunction

  // Largest divisor is 2 * 60 * 10^f.
  function automatic int unsigned dvs_w(input int unsigned f);
    return $clog2(120 * pow10_c(f) + 1);
  endfunction

  // Whole degrees stay below 10^(i-2).
  function automatic int unsigned deg_w(input int unsigned i);
    return $clog2(pow10_c(i - 2));
  endfunction

  // Dividend register covers the mantissa and 2 * minutes * 1e7 + 60 * 10^f.
  function automatic int unsigned num_w(input int unsigned i, input int unsigned f);
    int unsigned w2;
    w2 = $clog2(2 * E7 * 100 * pow10_c(f) + 60 * pow10_c(f));
    return (mant_w(i, f) > w2) ? mant_w(i, f) : w2;
  endfunction

  function automatic int unsigned cnt_w(input int unsigned i);
    return $clog2(max3(deg_w(i), FQ_W, MULC_W) + 1);
  endfunction

  // Power of ten selected by the kept fraction digit count.
  function automatic logic [63:0] pow10_rt(input logic [3:0] k);
    logic [63:0] p;
    case (k)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

### rtl/nmeacd_ctrl.sv
// ----------------------------------------------------------------------------
// NMEA coordinate converter controller
// Sequences character intake, the two divisions and the shift-add multiply,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`include "nmea_coordinate_to_degrees_e7_macros.svh"

module nmeacd_ctrl #(
  parameter int unsigned MAX_INT_DIGITS = nmeacd_pkg::MAX_INT_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_stall_o,
  input  nmeacd_pkg::sts_t  sts_i,
  output nmeacd_pkg::cmd_t  cmd_o
);

  localparam int unsigned DEG_W = nmeacd_pkg::deg_w(MAX_INT_DIGITS);
  localparam int unsigned CNT_W = nmeacd_pkg::cnt_w(MAX_INT_DIGITS);

  nmeacd_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nmeacd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      nmeacd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (!action_i) begin
            cmd_o.take_char = 1'b1;
          end else begin
            cmd_o.end_field = 1'b1;
            if (sts_i.field_ok) begin
              state_d = nmeacd_pkg::ST_DIV1;
              cnt_d   = CNT_W'(DEG_W);
            end else begin
              state_d = nmeacd_pkg::ST_SUM;
            end
          end
        end
      end
      nmeacd_pkg::ST_DIV1: begin
        if (cnt_q != '0) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q - CNT_W'(1);
        end else begin
          cmd_o.start_mul = 1'b1;
          cnt_d           = CNT_W'(nmeacd_pkg::MULC_W);
          state_d         = nmeacd_pkg::ST_MUL;
        end
      end
      nmeacd_pkg::ST_MUL: begin
        if (cnt_q != '0) begin
          cmd_o.mul_step = 1'b1;
          cnt_d          = cnt_q - CNT_W'(1);
        end else begin
          cmd_o.start_div2 = 1'b1;
          cnt_d            = CNT_W'(nmeacd_pkg::FQ_W);
          state_d          = nmeacd_pkg::ST_DIV2;
        end
      end
      nmeacd_pkg::ST_DIV2: begin
        if (cnt_q != '0) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q - CNT_W'(1);
        end else begin
          state_d = nmeacd_pkg::ST_SUM;
        end
      end
      nmeacd_pkg::ST_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = nmeacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nmeacd_pkg::ST_IDLE;
      end
    endcase
  end

  // A result is only written into a free output register.
  `NMEACD_ASSERT_IMPL(a_write_needs_free, cmd_o.write_out, sts_i.out_free, "result written over a pending one")
  // A well-formed field always starts the degree division.
  `NMEACD_ASSERT_NEXT(a_good_field_divides, cmd_o.end_field && sts_i.field_ok, state_q == nmeacd_pkg::ST_DIV1, "valid field did not start division")
  // The multiply never runs more steps than the constant has bits.
  `NMEACD_ASSERT_IMPL(a_mul_count_bound, state_q == nmeacd_pkg::ST_MUL, cnt_q <= CNT_W'(nmeacd_pkg::MULC_W), "multiply step count out of range")

endmodule

### rtl/nmeacd_dp.sv
// ----------------------------------------------------------------------------
// NMEA coordinate converter datapath
// Character parser, shared restoring divider, shift-add multiplier by 2e7,
// and the rounding, saturating output register.
// ----------------------------------------------------------------------------
`include "nmea_coordinate_to_degrees_e7_macros.svh"

module nmeacd_dp #(
  parameter int unsigned MAX_FRAC_DIGITS = nmeacd_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int unsigned MAX_INT_DIGITS  = nmeacd_pkg::MAX_INT_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nmeacd_pkg::cmd_t    cmd_i,
  output nmeacd_pkg::sts_t    sts_o,
  input  logic [7:0]          ch_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                ok_o,
  output logic signed [31:0]  coord_e7_o
);

  localparam int unsigned MANT_W = nmeacd_pkg::mant_w(MAX_INT_DIGITS, MAX_FRAC_DIGITS);
  localparam int unsigned DVS_W  = nmeacd_pkg::dvs_w(MAX_FRAC_DIGITS);
  localparam int unsigned DEG_W  = nmeacd_pkg::deg_w(MAX_INT_DIGITS);
  localparam int unsigned NUM_W  = nmeacd_pkg::num_w(MAX_INT_DIGITS, MAX_FRAC_DIGITS);
  localparam int unsigned Q_W    = (DEG_W > nmeacd_pkg::FQ_W) ? DEG_W : nmeacd_pkg::FQ_W;
  localparam int unsigned PROD_W = DEG_W + nmeacd_pkg::E7_W;
  localparam int unsigned MAG_W  = PROD_W + 1;
  localparam int unsigned SAT_W  = (MAG_W > 33) ? MAG_W : 33;
  localparam int unsigned IC_W   = $clog2(MAX_INT_DIGITS + 1);
  localparam int unsigned FC_W   = $clog2(MAX_FRAC_DIGITS + 1);

  // Parser state.
  logic [MANT_W-1:0]  mant_q, mant_d;
  logic [IC_W-1:0]    icnt_q, icnt_d;
  logic [FC_W-1:0]    fcnt_q, fcnt_d;
  nmeacd_pkg::phase_e phase_q, phase_d;
  logic               neg_q, neg_d;
  logic               ovf_q, ovf_d;

  // Arithmetic state.
  logic                   ok_q, hneg_q;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [DVS_W-1:0]       rem_q, rem_d;
  logic [DVS_W-1:0]       dvs_q, dvs_d;
  logic [Q_W-1:0]         quo_q, quo_d;
  logic [NUM_W-1:0]       mcand_q, mcand_d;
  logic [NUM_W-1:0]       acc_q, acc_d;
  logic [nmeacd_pkg::MULC_W-1:0] mulc_q, mulc_d;
  logic [PROD_W-1:0]      prod_q, prod_d;

  // Output register.
  logic               out_valid_q;
  logic               out_ok_q;
  logic signed [31:0] out_coord_q;

  // Character classification.
  logic              is_digit, is_space, is_sign, mant_zero, hemi_ok, hemi_neg;
  logic [3:0]        digit;
  logic [MANT_W-1:0] mant_x10;
  logic              int_path;

  assign is_digit  = (ch_i >= nmeacd_pkg::CH_ZERO) && (ch_i <= nmeacd_pkg::CH_NINE);
  assign is_space  = (ch_i == nmeacd_pkg::CH_SPACE) ||
                     ((ch_i >= nmeacd_pkg::CH_TAB) && (ch_i <= nmeacd_pkg::CH_CR));
  assign is_sign   = (ch_i == nmeacd_pkg::CH_PLUS) || (ch_i == nmeacd_pkg::CH_MINUS);
  assign digit     = ch_i[3:0];
  assign mant_zero = (mant_q == '0);
  assign mant_x10  = (mant_q << 3) + (mant_q << 1) + MANT_W'(digit);
  assign hemi_neg  = (ch_i == nmeacd_pkg::CH_S) || (ch_i == nmeacd_pkg::CH_W);
  assign hemi_ok   = hemi_neg || (ch_i == nmeacd_pkg::CH_N) || (ch_i == nmeacd_pkg::CH_E);

  assign sts_o.field_ok = !neg_q && !ovf_q && !mant_zero && hemi_ok;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Parser next state: skip leading blanks, take one sign, then digits.
  always_comb begin
    mant_d   = mant_q;
    icnt_d   = icnt_q;
    fcnt_d   = fcnt_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    int_path = 1'b0;
    if (cmd_i.write_out) begin
      mant_d  = '0;
      icnt_d  = '0;
      fcnt_d  = '0;
      phase_d = nmeacd_pkg::PH_LEAD;
      neg_d   = 1'b0;
      ovf_d   = 1'b0;
    end else if (cmd_i.take_char) begin
      case (phase_q)
        nmeacd_pkg::PH_LEAD: begin
          if (is_sign) begin
            neg_d   = neg_q || (ch_i == nmeacd_pkg::CH_MINUS);
            phase_d = nmeacd_pkg::PH_INT;
          end else if (!is_space) begin
            phase_d  = nmeacd_pkg::PH_INT;
            int_path = 1'b1;
          end
        end
        nmeacd_pkg::PH_INT: begin
          int_path = 1'b1;
        end
        nmeacd_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (fcnt_q < FC_W'(MAX_FRAC_DIGITS)) begin
              mant_d = mant_x10;
              fcnt_d = fcnt_q + FC_W'(1);
            end
          end else begin
            phase_d = nmeacd_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
      // Integer part: leading zeros are not counted.
      if (int_path) begin
        if (is_digit) begin
          if (!(mant_zero && (digit == 4'd0))) begin
            if (icnt_q < IC_W'(MAX_INT_DIGITS)) begin
              mant_d = mant_x10;
              icnt_d = icnt_q + IC_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end else if (ch_i == nmeacd_pkg::CH_DOT) begin
          phase_d = nmeacd_pkg::PH_FRAC;
        end else begin
          phase_d = nmeacd_pkg::PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mant_q  <= '0;
      icnt_q  <= '0;
      fcnt_q  <= '0;
      phase_q <= nmeacd_pkg::PH_LEAD;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      mant_q  <= mant_d;
      icnt_q  <= icnt_d;
      fcnt_q  <= fcnt_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

  // Divider, multiplier and scale selection.
  logic [3:0]       fsel;
  logic [NUM_W-1:0] n1;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign fsel  = 4'(fcnt_q);
  assign n1    = NUM_W'(mant_q);
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    mulc_d  = mulc_q;
    prod_d  = prod_q;
    if (cmd_i.end_field) begin
      // Degrees = mantissa / (100 * 10^f); quotient fits DEG_W bits.
      rem_d = DVS_W'(n1 >> DEG_W);
      num_d = n1 << (NUM_W - DEG_W);
      dvs_d = DVS_W'(nmeacd_pkg::pow10_rt(fsel) * 64'd100);
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d = {quo_q[Q_W-2:0], ge};
      num_d = num_q << 1;
    end else if (cmd_i.start_mul) begin
      // Whole degrees times 1e7; minutes remainder feeds the multiplier.
      prod_d  = PROD_W'(quo_q[DEG_W-1:0]) * PROD_W'(nmeacd_pkg::E7);
      mcand_d = NUM_W'(rem_q);
      acc_d   = NUM_W'(nmeacd_pkg::pow10_rt(fsel) * 64'd60);
      mulc_d  = nmeacd_pkg::TWO_E7;
    end else if (cmd_i.mul_step) begin
      if (mulc_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = mcand_q << 1;
      mulc_d  = mulc_q >> 1;
    end else if (cmd_i.start_div2) begin
      // Rounded minutes fraction = (2*min*1e7 + 60*10^f) / (120*10^f).
      rem_d = DVS_W'(acc_q >> nmeacd_pkg::FQ_W);
      num_d = acc_q << (NUM_W - nmeacd_pkg::FQ_W);
      dvs_d = DVS_W'(nmeacd_pkg::pow10_rt(fsel) * 64'd120);
      quo_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    mulc_q  <= mulc_d;
    prod_q  <= prod_d;
    if (cmd_i.end_field) begin
      ok_q   <= sts_o.field_ok;
      hneg_q <= hemi_neg;
    end
  end

  // Final sum, saturation and sign.
  logic [MAG_W-1:0] mag;
  logic [SAT_W-1:0] magx, lim, satv;
  logic [31:0]      sat32;

  assign mag   = MAG_W'(prod_q) + MAG_W'(quo_q[nmeacd_pkg::FQ_W-1:0]);
  assign magx  = SAT_W'(mag);
  assign lim   = hneg_q ? SAT_W'(64'h8000_0000) : SAT_W'(64'h7FFF_FFFF);
  assign satv  = (magx > lim) ? lim : magx;
  assign sat32 = satv[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_ok_q <= ok_q;
      if (!ok_q) begin
        out_coord_q <= 32'sd0;
      end else if (hneg_q) begin
        out_coord_q <= $signed(32'd0 - sat32);
      end else begin
        out_coord_q <= $signed(sat32);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign coord_e7_o  = out_coord_q;

  // A rejected field reports a zero coordinate.
  `NMEACD_ASSERT_IMPL(a_reject_is_zero, out_valid_q && !out_ok_q, out_coord_q == 32'sd0, "rejected field with nonzero coordinate")
  // Taking a character never shrinks the mantissa.
  `NMEACD_ASSERT_NEXT(a_mant_grows, cmd_i.take_char, mant_q >= $past(mant_q), "mantissa decreased on a character")

endmodule

### rtl/nmea_coordinate_to_degrees_e7.sv
// ----------------------------------------------------------------------------
// NMEA ddmm.mmmm coordinate to signed degrees times 1e7
// A value character is taken while the controller is idle; a valid hemisphere
// character starts the conversion, which runs the bit-serial divider twice and
// the 25-step shift-add multiply by 2e7. A rejected field skips the arithmetic.
// Input is stalled until the result enters a free output register. Reset clears
// the parser.
// ----------------------------------------------------------------------------
module nmea_coordinate_to_degrees_e7 #(
  parameter int unsigned MAX_FRAC_DIGITS = nmeacd_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int unsigned MAX_INT_DIGITS  = nmeacd_pkg::MAX_INT_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         ch_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [31:0] coord_e7_o
);

  nmeacd_pkg::cmd_t cmd;
  nmeacd_pkg::sts_t sts;

  // Sequencer for intake and conversion.
  nmeacd_ctrl #(
    .MAX_INT_DIGITS (MAX_INT_DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Parser, arithmetic and output register.
  nmeacd_dp #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .MAX_INT_DIGITS  (MAX_INT_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ch_i        (ch_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ok_o        (ok_o),
    .coord_e7_o  (coord_e7_o)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the NMEA coordinate to degrees-times-1e7 converter
// Sends coordinate fields one character per transaction, each ending with a
// hemisphere character. A scoreboard parses the same characters, predicts
// every result and checks each accepted result against the oldest one it
// predicted. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import nmeacd_pkg::*;

  localparam int unsigned MAX_FRAC = MAX_FRAC_DIGITS_DEF;
  localparam int unsigned MAX_INT  = MAX_INT_DIGITS_DEF;

  // Meaning of the action field.
  localparam bit ACT_VALUE = 1'b0;
  localparam bit ACT_HEMI  = 1'b1;

  localparam int TOTAL_ITEMS    = 1800;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  // Scoreboard: tracks the parse of the current field and the results due.
  class coord_scoreboard;
    typedef struct packed {
      logic        ok;
      logic [31:0] coord;
    } coord_result_t;

    coord_result_t   due_coords[$];
    longint unsigned digits_val;
    int unsigned     int_digits;
    int unsigned     frac_digits;
    phase_e          phase;
    bit              minus_seen;
    bit              too_long;
    int              mismatches;

    function new();
      mismatches = 0;
      clear_field();
    endfunction

    function void clear_field();
      digits_val  = 0;
      int_digits  = 0;
      frac_digits = 0;
      phase       = PH_LEAD;
      minus_seen  = 1'b0;
      too_long    = 1'b0;
    endfunction

    function int pending();
      return due_coords.size();
    endfunction

    function void note_input(bit act, logic [7:0] ch);
      longint unsigned scale, deg, mins, den, frac_e7, mag;
      bit              south_west;
      coord_result_t   res;
      // A value character only advances the parse.
      if (act == ACT_VALUE) begin
        if (phase == PH_LEAD) begin
          if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) return;
          if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (ch == CH_MINUS) minus_seen = 1'b1;
            phase = PH_INT;
            return;
          end
          phase = PH_INT;
        end
        if (phase == PH_INT) begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            // Leading zeros are not significant.
            if (!(digits_val == 0 && ch == CH_ZERO)) begin
              if (int_digits < MAX_INT) begin
                digits_val = digits_val * 10 + (ch - CH_ZERO);
                int_digits++;
              end else begin
                too_long = 1'b1;
              end
            end
          end else if (ch == CH_DOT) begin
            phase = PH_FRAC;
          end else begin
            phase = PH_DONE;
          end
        end else if (phase == PH_FRAC) begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (frac_digits < MAX_FRAC) begin
              digits_val = digits_val * 10 + (ch - CH_ZERO);
              frac_digits++;
            end
          end else begin
            phase = PH_DONE;
          end
        end
        return;
      end

      // The hemisphere character closes the field and yields one result.
      res.ok     = !minus_seen && !too_long && digits_val != 0;
      res.coord  = '0;
      south_west = (ch == CH_S || ch == CH_W);
      if (!south_west && ch != CH_N && ch != CH_E) res.ok = 1'b0;
      if (res.ok) begin
        scale = 1;
        repeat (frac_digits) scale = scale * 10;
        deg     = digits_val / (100 * scale);
        mins    = digits_val - deg * 100 * scale;
        den     = 60 * scale;
        frac_e7 = (2 * mins * E7 + den) / (2 * den);
        mag     = deg * E7 + frac_e7;
        if (south_west) begin
          if (mag > 64'd2147483648) mag = 64'd2147483648;
          res.coord = 32'(64'd0 - mag);
        end else begin
          if (mag > 64'd2147483647) mag = 64'd2147483647;
          res.coord = mag[31:0];
        end
      end
      due_coords.push_back(res);
      clear_field();
    endfunction

    function void check_result(logic ok, logic [31:0] coord);
      coord_result_t want;
      if (due_coords.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: ok=%0b coord=%0d", ok, $signed(coord));
        mismatches++;
        return;
      end
      want = due_coords.pop_front();
      if (ok !== want.ok || coord !== want.coord) begin
        if (mismatches < 10)
          $display("mismatch: expected ok=%0b coord=%0d, got ok=%0b coord=%0d",
                   want.ok, $signed(want.coord), ok, $signed(coord));
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               action_i    = 1'b0;
  logic [7:0]         ch_i        = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               ok_o;
  logic signed [31:0] coord_e7_o;

  coord_scoreboard sb;
  bit              in_calm;
  bit              out_calm;
  int              items_sent;

  nmea_coordinate_to_degrees_e7 #(
    .MAX_FRAC_DIGITS(MAX_FRAC),
    .MAX_INT_DIGITS (MAX_INT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .ch_i       (ch_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .coord_e7_o (coord_e7_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Drive one transaction and wait until it is accepted.
  task automatic send_item(bit act, logic [7:0] ch);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    ch_i       <= ch;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, ch);
    items_sent++;
  endtask

  task automatic send_field(string value, logic [7:0] hemi);
    for (int i = 0; i < value.len(); i++) send_item(ACT_VALUE, value[i]);
    send_item(ACT_HEMI, hemi);
  endtask

  task automatic send_digits(int count, bit zeros);
    for (int i = 0; i < count; i++)
      send_item(ACT_VALUE, zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // One random field: mostly well formed with random content, some noise.
  task automatic send_random_field();
    int         r;
    logic [7:0] hemi;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(0, 8)) send_item(ACT_VALUE, 8'($urandom_range(0, 255)));
      send_item(ACT_HEMI, 8'($urandom_range(0, 255)));
      return;
    end
    // Leading white space.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3))
        send_item(ACT_VALUE, ($urandom_range(0, 1) == 0) ? CH_SPACE
                                                        : CH_TAB + 8'($urandom_range(0, 4)));
    end
    // Optional sign, rarely a minus.
    r = $urandom_range(0, 19);
    if (r < 2) send_item(ACT_VALUE, CH_MINUS);
    else if (r < 6) send_item(ACT_VALUE, CH_PLUS);
    // Leading zeros, then the integer part: usually dmm, ddmm or dddmm.
    if ($urandom_range(0, 5) == 0) send_digits($urandom_range(1, 3), 1'b1);
    if ($urandom_range(0, 9) == 0) send_digits($urandom_range(0, 7), 1'b0);
    else send_digits($urandom_range(3, 5), 1'b0);
    // Fraction part.
    if ($urandom_range(0, 99) < 85) begin
      send_item(ACT_VALUE, CH_DOT);
      if ($urandom_range(0, 9) == 0) send_digits($urandom_range(1, 9), 1'b1);
      else send_digits($urandom_range(0, 9), 1'b0);
    end
    // Trailing random characters; the parse ignores those after the number ends.
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) send_item(ACT_VALUE, 8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 9))
      0: hemi = CH_N;
      1, 2: hemi = CH_S;
      3, 4: hemi = CH_E;
      5, 6: hemi = CH_W;
      7: hemi = 8'($urandom_range(0, 255));
      default: hemi = ($urandom_range(0, 1) == 0) ? CH_N : CH_E;
    endcase
    send_item(ACT_HEMI, hemi);
  endtask

  // Result side: check each accepted result, then choose the next stall.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(ok_o, coord_e7_o);
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap(out_calm);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int fields;
    sb         = new();
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    items_sent = 0;
    fields     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed fields: every hemisphere, every rejection and the edge values.
    send_field("4807.038", CH_N);
    send_field("01131.000", CH_E);
    send_field("4807.038", CH_S);
    send_field("01131.000", CH_W);
    send_field("  +1234.5678901", CH_N);    // blanks, plus sign, full fraction
    send_field("-4807.038", CH_N);          // minus sign rejects
    send_field("", CH_N);                   // empty field
    send_field("0000.0000", CH_E);          // zero value
    send_field("123456.0", CH_N);           // too many integer digits
    send_field("00000123.4", CH_N);         // leading zeros do not count
    send_field("99999.9999999", CH_S);      // saturates negative
    send_field("21500", CH_N);              // saturates positive
    send_field("1260.0", CH_E);             // sixty minutes taken as is
    send_field("12.5x9", CH_N);             // stops at a letter
    send_field("1e5", CH_E);                // no exponent form
    send_field("+-5", CH_N);                // second sign ends the number
    send_field(".5", CH_N);
    send_field("5.", CH_W);
    send_field("4807.038", 8'hFF);          // bad hemisphere
    for (int c = CH_TAB; c <= CH_CR; c++) send_item(ACT_VALUE, 8'(c));
    send_field("12", CH_N);                 // every white space character
    send_item(ACT_VALUE, 8'h00);
    send_field("12", CH_N);                 // NUL as first character

    // Random fields, with stretches of no idling on either side.
    while (items_sent < TOTAL_ITEMS) begin
      if (fields % 25 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      send_random_field();
      fields++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
